### sv/log_line_field_splitter_macros.svh
// Assertion macros shared by the log line field splitter RTL.
`ifndef LOG_LINE_FIELD_SPLITTER_MACROS_SVH
`define LOG_LINE_FIELD_SPLITTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge, suspended while reset is asserted.
`define LLFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define LLFS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LLFS_ASSERT(lbl, prop, msg)
`define LLFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/llfs_pkg.sv
// Types and constants of the log line field splitter.
package llfs_pkg;

	localparam int MAX_LINE = 128;
	localparam int POS_W    = $clog2(MAX_LINE);

	localparam int CHAR_W   = 8;
	localparam int MANT_W   = 48;
	localparam int FRAC_W   = 7;
	localparam int DIGIT_W  = 4;
	localparam int KIND_W   = 3;
	localparam int FIELD_W  = 2;

	localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};
	localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};
	localparam logic [POS_W-1:0]  POS_LAST = POS_W'(MAX_LINE - 1);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
	localparam int                NUM_BASE = 10;

	localparam logic [FIELD_W-1:0] FIELD_DATE = 2'd0;
	localparam logic [FIELD_W-1:0] FIELD_NAME = 2'd1;
	localparam logic [FIELD_W-1:0] FIELD_REST = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATE_CHAR = 3'd0,
		KIND_DATE_END  = 3'd1,
		KIND_NAME_CHAR = 3'd2,
		KIND_NAME_END  = 3'd3,
		KIND_LINE_DONE = 3'd4,
		KIND_TOO_LONG  = 3'd5
	} kind_t;

endpackage

### sv/llfs_mant_step.sv
// One decimal digit step of the mantissa: times ten plus digit, held at the maximum.
module llfs_mant_step (
	input  logic [llfs_pkg::MANT_W-1:0]  acc,
	input  logic [llfs_pkg::DIGIT_W-1:0] digit,
	output logic [llfs_pkg::MANT_W-1:0]  acc_next,
	output logic                         overflow
);

	localparam int WIDE_W = llfs_pkg::MANT_W + 4;

	logic [WIDE_W-1:0] wide;

	// Times ten as eight times plus two times.
	assign wide     = (WIDE_W'(acc) << 3) + (WIDE_W'(acc) << 1) + WIDE_W'(digit);
	assign overflow = (wide > WIDE_W'(llfs_pkg::MANT_MAX));
	assign acc_next = overflow ? llfs_pkg::MANT_MAX : wide[llfs_pkg::MANT_W-1:0];

endmodule

### sv/log_line_field_splitter.sv
// Log line field splitter: takes one line byte per word and emits tagged field words.
// A result word passes through the input register and then the output register on its way out.
// Throughput: one input word per cycle; a word that gives no result never waits.
// The input stage stalls only while a result is due and the output register is still full.
// Reset clears all line state at once; there is no memory and no clearing pass.
`include "log_line_field_splitter_macros.svh"

module log_line_field_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [7:0] char_out, [55:8] mantissa, [62:56] frac_digits,
	                               // [63] saturated
	output logic [2:0]  m_tuser    // [2:0] kind
);

	// Input register stage.
	logic                         valid_s1;
	logic [llfs_pkg::CHAR_W-1:0]  char_s1;

	// Line state.
	logic [llfs_pkg::FIELD_W-1:0] field_q;
	logic [llfs_pkg::POS_W-1:0]   position_q;
	logic [llfs_pkg::MANT_W-1:0]  acc_q;
	logic [llfs_pkg::FRAC_W-1:0]  frac_q;
	logic                         dot_q;
	logic                         sat_q;
	logic                         discard_q;

	// Output register.
	logic                         out_valid_q;
	llfs_pkg::kind_t              out_kind_q;
	logic [llfs_pkg::CHAR_W-1:0]  out_char_q;
	logic [llfs_pkg::MANT_W-1:0]  out_mant_q;
	logic [llfs_pkg::FRAC_W-1:0]  out_frac_q;
	logic                         out_sat_q;

	// Next state and result.
	logic [llfs_pkg::FIELD_W-1:0] field_d;
	logic [llfs_pkg::POS_W-1:0]   position_d;
	logic [llfs_pkg::MANT_W-1:0]  acc_d;
	logic [llfs_pkg::FRAC_W-1:0]  frac_d;
	logic                         dot_d;
	logic                         sat_d;
	logic                         discard_d;
	logic                         res_valid;
	llfs_pkg::kind_t              res_kind;
	logic [llfs_pkg::CHAR_W-1:0]  res_char;
	logic [llfs_pkg::MANT_W-1:0]  res_mant;
	logic [llfs_pkg::FRAC_W-1:0]  res_frac;
	logic                         res_sat;

	logic                         is_digit;
	logic [llfs_pkg::MANT_W-1:0]  acc_step;
	logic                         acc_ovf;
	logic                         out_free;
	logic                         go_s1;

	assign is_digit = (char_s1 >= llfs_pkg::CH_ZERO) && (char_s1 <= llfs_pkg::CH_NINE);

	llfs_mant_step u_mant_step (
		.acc      (acc_q),
		.digit    (char_s1[llfs_pkg::DIGIT_W-1:0]),
		.acc_next (acc_step),
		.overflow (acc_ovf)
	);

	always_comb begin
		field_d    = field_q;
		position_d = position_q;
		acc_d      = acc_q;
		frac_d     = frac_q;
		dot_d      = dot_q;
		sat_d      = sat_q;
		discard_d  = discard_q;
		res_valid  = 1'b0;
		res_kind   = llfs_pkg::KIND_LINE_DONE;
		res_char   = '0;
		res_mant   = '0;
		res_frac   = '0;
		res_sat    = 1'b0;

		if (discard_q) begin
			if (char_s1 == llfs_pkg::CH_NUL) begin
				field_d    = llfs_pkg::FIELD_DATE;
				position_d = '0;
				acc_d      = '0;
				frac_d     = '0;
				dot_d      = 1'b0;
				sat_d      = 1'b0;
				discard_d  = 1'b0;
			end
		end else if (char_s1 == llfs_pkg::CH_NUL) begin
			res_valid  = 1'b1;
			res_kind   = llfs_pkg::KIND_LINE_DONE;
			res_mant   = acc_q;
			res_frac   = frac_q;
			res_sat    = sat_q;
			field_d    = llfs_pkg::FIELD_DATE;
			position_d = '0;
			acc_d      = '0;
			frac_d     = '0;
			dot_d      = 1'b0;
			sat_d      = 1'b0;
		end else if (position_q >= llfs_pkg::POS_LAST) begin
			res_valid = 1'b1;
			res_kind  = llfs_pkg::KIND_TOO_LONG;
			discard_d = 1'b1;
		end else begin
			position_d = position_q + 1'b1;
			if (char_s1 == llfs_pkg::CH_SPACE) begin
				// Only the first two spaces end a field; later ones are dropped.
				if (field_q != llfs_pkg::FIELD_REST) begin
					res_valid = 1'b1;
					res_kind  = (field_q == llfs_pkg::FIELD_DATE) ?
					            llfs_pkg::KIND_DATE_END : llfs_pkg::KIND_NAME_END;
					field_d   = field_q + 1'b1;
					acc_d     = '0;
					frac_d    = '0;
					dot_d     = 1'b0;
					sat_d     = 1'b0;
				end
			end else begin
				if (char_s1 == llfs_pkg::CH_DOT) begin
					dot_d = 1'b1;
				end else if (is_digit) begin
					acc_d = acc_step;
					if (acc_ovf) begin
						sat_d = 1'b1;
					end
					if (dot_q && (frac_q != llfs_pkg::FRAC_MAX)) begin
						frac_d = frac_q + 1'b1;
					end
				end
				if (field_q != llfs_pkg::FIELD_REST) begin
					res_valid = 1'b1;
					res_kind  = (field_q == llfs_pkg::FIELD_DATE) ?
					            llfs_pkg::KIND_DATE_CHAR : llfs_pkg::KIND_NAME_CHAR;
					res_char  = char_s1;
				end
			end
		end
	end

	// A word that gives a result waits for room in the output register.
	assign out_free = !out_valid_q || m_tready;
	assign go_s1    = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			field_q     <= llfs_pkg::FIELD_DATE;
			position_q  <= '0;
			acc_q       <= '0;
			frac_q      <= '0;
			dot_q       <= 1'b0;
			sat_q       <= 1'b0;
			discard_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (go_s1) begin
				field_q    <= field_d;
				position_q <= position_d;
				acc_q      <= acc_d;
				frac_q     <= frac_d;
				dot_q      <= dot_d;
				sat_q      <= sat_d;
				discard_q  <= discard_d;
			end
			if (go_s1 && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
		if (go_s1 && res_valid) begin
			out_kind_q <= res_kind;
			out_char_q <= res_char;
			out_mant_q <= res_mant;
			out_frac_q <= res_frac;
			out_sat_q  <= res_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_sat_q, out_frac_q, out_mant_q, out_char_q};
	assign m_tuser  = out_kind_q;

	`LLFS_ASSERT(a_pos_bound, position_q <= llfs_pkg::POS_LAST, "position beyond line limit")
	`LLFS_ASSERT(a_sat_held, !sat_q || (acc_q == llfs_pkg::MANT_MAX), "saturation not held")
	`LLFS_ASSERT(a_frac_dot, (frac_q == '0) || dot_q, "fraction digits counted without a dot")
	`LLFS_ASSERT(a_number_only_done, (m_tvalid && (m_tuser != llfs_pkg::KIND_LINE_DONE)) |-> ((m_tdata[63:8] == '0)), "number fields set on a word other than line done")
	`LLFS_ASSERT(a_discard_silent, (go_s1 && discard_q) |=> $stable(out_valid_q) || !out_valid_q, "result produced while swallowing a line")

endmodule

### tb/tb.sv
// Self-checking testbench for the log line field splitter.
module tb;
	import llfs_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_BYTES  = 380;
	localparam int END_CYCLES   = 8;
	localparam int REPORT_LIMIT = 10;

	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CH_Z     = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_TOP   = 8'hFF;

	typedef enum int {SHAPE_LOG, SHAPE_NUMBER, SHAPE_NOISE, SHAPE_BROKEN, SHAPE_LONG} line_shape_t;

	typedef logic [CHAR_W-1:0] line_bytes_t[$];

	typedef struct {
		kind_t              kind;
		logic [CHAR_W-1:0]  ch;
		logic [MANT_W-1:0]  mant;
		logic [FRAC_W-1:0]  frac;
		logic               sat;
	} field_word_t;

	class splitter_scoreboard;
		field_word_t        pending_words[$];
		int unsigned        mismatches = 0;
		logic [FIELD_W-1:0] spaces_seen = FIELD_DATE;
		int unsigned        taken = 0;
		logic [MANT_W-1:0]  acc = '0;
		logic [FRAC_W-1:0]  frac = '0;
		bit                 dot = 1'b0;
		bit                 sat = 1'b0;
		bit                 swallowing = 1'b0;

		function void clear_number();
			acc  = '0;
			frac = '0;
			dot  = 1'b0;
			sat  = 1'b0;
		endfunction

		function void clear_line();
			spaces_seen = FIELD_DATE;
			taken       = 0;
			swallowing  = 1'b0;
			clear_number();
		endfunction

		// Works out the word, if any, that one accepted line byte gives.
		function void note_byte(logic [CHAR_W-1:0] c);
			field_word_t       w;
			logic [MANT_W-1:0] d;
			w = '{kind: KIND_LINE_DONE, ch: '0, mant: '0, frac: '0, sat: 1'b0};
			if (swallowing) begin
				if (c == CH_NUL)
					clear_line();
				return;
			end
			if (c == CH_NUL) begin
				w.mant = acc;
				w.frac = frac;
				w.sat  = sat;
				clear_line();
				pending_words.push_back(w);
				return;
			end
			if (taken >= MAX_LINE - 1) begin
				swallowing = 1'b1;
				w.kind = KIND_TOO_LONG;
				pending_words.push_back(w);
				return;
			end
			taken++;
			if (c == CH_SPACE) begin
				// Spaces after the second one neither end a field nor clear the number.
				if (spaces_seen == FIELD_REST)
					return;
				if (spaces_seen == FIELD_DATE)
					w.kind = KIND_DATE_END;
				else
					w.kind = KIND_NAME_END;
				spaces_seen++;
				clear_number();
				pending_words.push_back(w);
				return;
			end
			if (c == CH_DOT) begin
				dot = 1'b1;
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				d = MANT_W'(c - CH_ZERO);
				if (acc > (MANT_MAX - d) / NUM_BASE) begin
					acc = MANT_MAX;
					sat = 1'b1;
				end else begin
					acc = acc * NUM_BASE + d;
				end
				if (dot && frac != FRAC_MAX)
					frac++;
			end
			if (spaces_seen == FIELD_REST)
				return;
			if (spaces_seen == FIELD_DATE)
				w.kind = KIND_DATE_CHAR;
			else
				w.kind = KIND_NAME_CHAR;
			w.ch = c;
			pending_words.push_back(w);
		endfunction

		function void check_word(logic [KIND_W-1:0] kind, logic [63:0] data);
			field_word_t w;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected word, kind %0d data %h", $time, kind, data);
				return;
			end
			w = pending_words.pop_front();
			if (kind !== w.kind || data[7:0] !== w.ch || data[55:8] !== w.mant ||
			    data[62:56] !== w.frac || data[63] !== w.sat) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: word mismatch, expected kind %0d char %h mant %0d frac %0d sat %b",
					         $time, w.kind, w.ch, w.mant, w.frac, w.sat);
					$display("    got kind %0d char %h mant %0d frac %0d sat %b",
					         kind, data[7:0], data[55:8], data[62:56], data[63]);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [CHAR_W-1:0]  s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [63:0]        m_tdata;
	logic [KIND_W-1:0]  m_tuser;

	splitter_scoreboard sb = new();

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycle_count = 0;
	bit          hold_req = 1'b0;

	log_line_field_splitter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The input word is noted before the output is checked, so any latency is handled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_byte(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_word(m_tuser, m_tdata);
		end
	end

	// Receiver: random stalls, and one long hold-off when asked for.
	initial begin
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
				@(negedge clk);
			end
		end
	end

	function automatic logic [CHAR_W-1:0] any_byte();
		return CHAR_W'($urandom_range(255, 1));
	endfunction

	function automatic logic [CHAR_W-1:0] digit_byte();
		return CH_ZERO + CHAR_W'($urandom_range(9));
	endfunction

	function automatic logic [CHAR_W-1:0] date_byte();
		case ($urandom_range(15))
			0:       return any_byte();
			1:       return CH_DASH;
			2:       return CH_COLON;
			3:       return CH_DOT;
			default: return digit_byte();
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] name_byte();
		case ($urandom_range(15))
			0:       return any_byte();
			1, 2:    return digit_byte();
			default: return CHAR_W'($urandom_range(CH_Z, CH_A));
		endcase
	endfunction

	function automatic line_bytes_t make_line(input bit long_line);
		line_bytes_t q;
		line_shape_t shape;
		int unsigned roll;
		roll = $urandom_range(99);
		if (long_line || roll >= 97)
			shape = SHAPE_LONG;
		else if (roll < 60)
			shape = SHAPE_LOG;
		else if (roll < 72)
			shape = SHAPE_NUMBER;
		else if (roll < 84)
			shape = SHAPE_NOISE;
		else
			shape = SHAPE_BROKEN;
		case (shape)
			SHAPE_LOG: begin
				repeat ($urandom_range(10, 3)) q.push_back(date_byte());
				q.push_back(CH_SPACE);
				repeat ($urandom_range(8, 1)) q.push_back(name_byte());
				q.push_back(CH_SPACE);
				repeat ($urandom_range(2)) begin
					repeat ($urandom_range(5, 1)) q.push_back(name_byte());
					q.push_back(CH_SPACE);
				end
				repeat ($urandom_range(6)) q.push_back(digit_byte());
				if ($urandom_range(1))
					q.push_back(CH_DOT);
				repeat ($urandom_range(6)) q.push_back(digit_byte());
			end
			SHAPE_NUMBER: begin
				// Long digit runs push the mantissa into saturation.
				if ($urandom_range(1)) begin
					q.push_back(digit_byte());
					q.push_back(CH_SPACE);
					q.push_back(name_byte());
					q.push_back(CH_SPACE);
				end
				repeat ($urandom_range(22, 10))
					q.push_back(($urandom_range(7) == 0) ? CH_DOT : digit_byte());
			end
			SHAPE_NOISE: begin
				repeat ($urandom_range(16)) q.push_back(any_byte());
			end
			SHAPE_BROKEN: begin
				repeat ($urandom_range(12)) begin
					case ($urandom_range(3))
						0:       q.push_back(CH_SPACE);
						1:       q.push_back(CH_DOT);
						2:       q.push_back(digit_byte());
						default: q.push_back(any_byte());
					endcase
				end
			end
			default: begin
				// Lengths around the line limit: some end just in time, most overrun it.
				repeat ($urandom_range(134, 124)) begin
					case ($urandom_range(9))
						0:       q.push_back(CH_SPACE);
						1:       q.push_back(CH_DOT);
						2:       q.push_back(any_byte());
						default: q.push_back(digit_byte());
					endcase
				end
			end
		endcase
		q.push_back(CH_NUL);
		return q;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_byte(input logic [CHAR_W-1:0] c);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_line(input line_bytes_t line);
		foreach (line[i]) send_byte(line[i]);
	endtask

	initial begin
		line_bytes_t directed;
		int unsigned phase_start;
		// Date, name, a third space, repeated dots, a line with no spaces, an empty line.
		directed = '{CH_ZERO + 8'd1, CH_TOP, CH_SPACE, CH_A, CH_DOT, CH_SPACE,
		             CH_ZERO + 8'd2, CH_DOT, CH_ZERO + 8'd5, CH_DOT, CH_ZERO + 8'd7,
		             CH_SPACE, CH_NINE, CH_NUL,
		             8'h01, CH_ZERO + 8'd7, CH_DOT, CH_ZERO + 8'd2, CH_ZERO + 8'd5, CH_NUL,
		             CH_NUL};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		tx_idle_pct = 24;
		rx_idle_pct = 69;
		send_line(directed);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 24;
					rx_idle_pct = 69;
				end
				1: begin
					tx_idle_pct = 69;
					rx_idle_pct = 24;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			phase_start = bytes_sent;
			send_line(make_line(1'b1));
			// With the sender never idle, a long hold-off fills the block up.
			if (phase == 2)
				hold_req = 1'b1;
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_line(make_line(1'b0));
		end
		s_tvalid <= 1'b0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
